// ----- sv/gfr_pkg.sv -----
// ----------------------------------------------------------------------------
// gfr_pkg
// shared types, codes and constants of the gauge frame receiver
// ----------------------------------------------------------------------------
package gfr_pkg;

    localparam int RX_DEPTH_DEFAULT = 8;

    localparam logic [6:0]  OWN_ADDR_RESET = 7'h41;
    localparam logic [15:0] STALE_RESET    = 16'd12000;

    localparam logic [7:0] CRC_POLY    = 8'h07;
    localparam logic [7:0] CMD_PERCENT = 8'h26;
    localparam logic [7:0] CMD_CURRENT = 8'h06;
    localparam logic [7:0] SUB_PERCENT = 8'h02;
    localparam logic [7:0] LEN_CURRENT = 8'h03;
    localparam logic [7:0] PERCENT_MAX = 8'd100;
    localparam int         ECHO_MIN_LEN = 5;
    localparam int         PCT_LEN      = 4;
    localparam int         CUR_LEN      = 5;

    // configuration register indexes
    localparam logic CFG_OWN_ADDRESS = 1'b0;
    localparam logic CFG_STALE_LIMIT = 1'b1;

    typedef enum logic [1:0] {
        FN_START = 2'd0,
        FN_DATA  = 2'd1,
        FN_STOP  = 2'd2,
        FN_TICK  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_PERCENT = 2'd1,
        KIND_CURRENT = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_SEED,
        SQ_WALK,
        SQ_DONE
    } seq_state_t;

    // status from the frame sequencer to the top level
    typedef struct packed {
        logic        idle;
        logic        done;
        kind_t       kind;
        logic [7:0]  value;
        logic [15:0] counts;
    } seq_stat_t;

    // one result, lowest field in the lowest bits
    typedef struct packed {
        logic [1:0]  pad;
        logic [31:0] current_age_ms;
        logic        current_present;
        logic [15:0] current_raw;
        logic [31:0] percent_age_ms;
        logic        percent_fresh;
        logic        percent_present;
        logic [7:0]  percent_value;
        kind_t       frame_kind;
        logic        byte_accepted;
    } result_t;

endpackage

// ----- sv/gfr_crc_unit.sv -----
// ----------------------------------------------------------------------------
// gfr_crc_unit
// one byte step of crc-8, polynomial 0x07, msb first
// ----------------------------------------------------------------------------
module gfr_crc_unit (
    input  logic [7:0] crc_in,
    input  logic [7:0] byte_in,
    output logic [7:0] crc_out
);
    import gfr_pkg::*;

    always_comb begin
        logic [7:0] c;
        c = crc_in ^ byte_in;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        crc_out = c;
    end

endmodule

// ----- sv/gfr_rx_buffer.sv -----
// ----------------------------------------------------------------------------
// gfr_rx_buffer
// byte store of one write with fill count and one read port
// ----------------------------------------------------------------------------
module gfr_rx_buffer #(
    parameter int RX_DEPTH = gfr_pkg::RX_DEPTH_DEFAULT,
    localparam int CNT_W = $clog2(RX_DEPTH + 1),
    localparam int IDX_W = $clog2(RX_DEPTH)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             clear,
    input  logic             wr_en,
    input  logic [7:0]       wr_data,
    input  logic [IDX_W-1:0] rd_idx,
    output logic [7:0]       rd_data,
    output logic [7:0]       byte0,
    output logic [CNT_W-1:0] count,
    output logic             full
);
    import gfr_pkg::*;

    logic [7:0]       buf_mem [RX_DEPTH];
    logic [7:0]       rd_data_reg;
    logic [7:0]       byte0_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full    = (count_reg == CNT_W'(RX_DEPTH));
    assign count   = count_reg;
    assign rd_data = rd_data_reg;
    assign byte0   = byte0_reg;

    always_comb begin
        count_next = count_reg;
        if (clear) begin
            count_next = '0;
        end else if (wr_en && !full) begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // read data is registered from the address; byte0 is only looked at
    // once five bytes are held, long after it was written
    always_ff @(posedge aclk) begin
        if (wr_en && !full && !clear) begin
            buf_mem[count_reg[IDX_W-1:0]] <= wr_data;
        end
        rd_data_reg <= buf_mem[rd_idx];
        byte0_reg   <= buf_mem[0];
    end

endmodule

// ----- sv/gfr_frame_seq.sv -----
// ----------------------------------------------------------------------------
// gfr_frame_seq
// stop-time sequencer: walks the buffered frame through the shared crc unit
// ----------------------------------------------------------------------------
module gfr_frame_seq #(
    parameter int RX_DEPTH = gfr_pkg::RX_DEPTH_DEFAULT,
    localparam int CNT_W = $clog2(RX_DEPTH + 1),
    localparam int IDX_W = $clog2(RX_DEPTH)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [7:0]         addr_byte,
    input  logic [CNT_W-1:0]   rx_count,
    input  logic [7:0]         byte0,
    input  logic [7:0]         rd_data,
    input  logic               res_take,
    output logic [IDX_W-1:0]   rd_idx,
    output gfr_pkg::seq_stat_t stat
);
    import gfr_pkg::*;

    seq_state_t       state_reg, state_next;
    logic [7:0]       crc_reg, crc_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic [IDX_W-1:0] last_reg, last_next;
    logic [1:0]       off_reg, off_next;
    kind_t            cand_reg, cand_next;
    kind_t            kind_reg, kind_next;
    logic [7:0]       fld_reg [4];
    logic [7:0]       crc_in, crc_byte, crc_out;
    logic             echo;
    logic             at_last;
    logic             pct_ok, cur_ok;

    gfr_crc_unit u_crc (
        .crc_in  (crc_in),
        .byte_in (crc_byte),
        .crc_out (crc_out)
    );

    assign echo    = (rx_count >= CNT_W'(ECHO_MIN_LEN)) && (byte0 == addr_byte);
    assign at_last = (k_reg == last_reg);
    assign pct_ok  = (fld_reg[0] == CMD_PERCENT) && (fld_reg[1] == SUB_PERCENT)
                     && (fld_reg[2] <= PERCENT_MAX);
    assign cur_ok  = (fld_reg[0] == CMD_CURRENT) && (fld_reg[1] == LEN_CURRENT);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            SQ_IDLE: begin
                if (start) begin
                    if ((rx_count == CNT_W'(PCT_LEN) + CNT_W'(echo)) ||
                        (rx_count == CNT_W'(CUR_LEN) + CNT_W'(echo))) begin
                        state_next = SQ_SEED;
                    end else begin
                        state_next = SQ_DONE;
                    end
                end
            end
            SQ_SEED: state_next = SQ_WALK;
            SQ_WALK: begin
                if (at_last) begin
                    state_next = SQ_DONE;
                end
            end
            SQ_DONE: begin
                if (res_take) begin
                    state_next = SQ_IDLE;
                end
            end
            default: state_next = SQ_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        crc_next  = crc_reg;
        k_next    = k_reg;
        last_next = last_reg;
        off_next  = off_reg;
        cand_next = cand_reg;
        kind_next = kind_reg;
        crc_in    = crc_reg;
        crc_byte  = rd_data;
        case (state_reg)
            SQ_IDLE: begin
                if (start) begin
                    k_next    = IDX_W'(echo);
                    last_next = IDX_W'(rx_count - CNT_W'(1));
                    off_next  = '0;
                    kind_next = KIND_NONE;
                    cand_next = (rx_count == CNT_W'(PCT_LEN) + CNT_W'(echo)) ?
                                KIND_PERCENT : KIND_CURRENT;
                end
            end
            SQ_SEED: begin
                crc_in   = '0;
                crc_byte = addr_byte;
                crc_next = crc_out;
            end
            SQ_WALK: begin
                if (at_last) begin
                    if (crc_reg == rd_data &&
                        ((cand_reg == KIND_PERCENT && pct_ok) ||
                         (cand_reg == KIND_CURRENT && cur_ok))) begin
                        kind_next = cand_reg;
                    end
                end else begin
                    crc_next = crc_out;
                    k_next   = k_reg + IDX_W'(1);
                    off_next = off_reg + 2'd1;
                end
            end
            default: ;
        endcase
        // the buffer read is registered, so it is addressed with the next index
        rd_idx      = k_next;
        stat.idle   = (state_reg == SQ_IDLE);
        stat.done   = (state_reg == SQ_DONE);
        stat.kind   = kind_reg;
        stat.value  = fld_reg[2];
        stat.counts = {fld_reg[3], fld_reg[2]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SQ_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        crc_reg  <= crc_next;
        k_reg    <= k_next;
        last_reg <= last_next;
        off_reg  <= off_next;
        cand_reg <= cand_next;
        kind_reg <= kind_next;
        if (state_reg == SQ_WALK && !at_last) begin
            fld_reg[off_reg] <= rd_data;
        end
    end

endmodule

// ----- sv/gauge_frame_receiver_unit.sv -----
// ----------------------------------------------------------------------------
// gauge_frame_receiver_unit
// receive side of a bus target that collects gauge percent and current frames
// ----------------------------------------------------------------------------
// usage:
//   s_ channel: one request per bus event; s_tuser is the event code
//   (write start, data byte, stop, millisecond tick), s_tdata the byte.
//   m_ channel: exactly one result per request, carrying the byte-accept
//   flag, the frame kind at stop and the kept percent and current values
//   with their seen flags and ages, and the percent freshness.
//   cfg_ channel: index 0 own address, index 1 stale limit in ms; always
//   ready; the user keeps it written only while the block is idle (unchecked).
// flow:
//   start, data and tick requests: result in the output register the cycle
//   after acceptance, one request per cycle while the output drains.
//   stop: the crc unit is seeded with the address write byte, then fed one
//   frame byte a cycle (an echoed address byte skipped); the result is
//   loaded in the done state once the output is free, and a length that
//   fits no frame goes to done directly; s_tready is low until the load.
// reset: buffer count, kept values, seen flags and ages clear, the
//   registers take their defaults (address 0x41, limit 12000 ms).
// stall: while a result is held and m_tready is low, the output register
//   keeps it and no new request is taken.
// ----------------------------------------------------------------------------
module gauge_frame_receiver_unit #(
    parameter int RX_DEPTH = gfr_pkg::RX_DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    input  logic [1:0]  s_tuser,   // func[1:0]
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    // byte_accepted[0], frame_kind[2:1], percent_value[10:3],
    // percent_present[11], percent_fresh[12], percent_age_ms[44:13],
    // current_raw[60:45], current_present[61], current_age_ms[93:62], zeros
    output logic [95:0] m_tdata,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    import gfr_pkg::*;

    localparam int CNT_W = $clog2(RX_DEPTH + 1);
    localparam int IDX_W = $clog2(RX_DEPTH);

    // configuration
    logic [6:0]  own_address_reg, own_address_next;
    logic [15:0] stale_limit_reg, stale_limit_next;

    // kept values
    logic [7:0]  percent_store_reg, percent_store_next;
    logic        percent_valid_reg, percent_valid_next;
    logic [31:0] percent_age_reg, percent_age_next;
    logic [15:0] current_store_reg, current_store_next;
    logic        current_valid_reg, current_valid_next;
    logic [31:0] current_age_reg, current_age_next;

    // output register
    result_t     out_data_reg, out_data_next;
    logic        out_valid_reg, out_valid_next;

    logic             in_take;
    func_t            func;
    logic             out_free;
    logic             load;
    logic             accepted;
    kind_t            kind;
    logic [7:0]       addr_byte;
    logic [IDX_W-1:0] rd_idx;
    logic [7:0]       rd_data;
    logic [7:0]       byte0;
    logic [CNT_W-1:0] rx_count;
    logic             rx_full;
    logic             seq_take;
    seq_stat_t        seq_stat;

    assign func      = func_t'(s_tuser);
    assign addr_byte = {own_address_reg, 1'b0};
    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = seq_stat.idle && out_free;
    assign in_take   = s_tvalid && s_tready;
    assign seq_take  = seq_stat.done && out_free;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    gfr_rx_buffer #(
        .RX_DEPTH (RX_DEPTH)
    ) u_buffer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (in_take && func == FN_START),
        .wr_en   (in_take && func == FN_DATA),
        .wr_data (s_tdata),
        .rd_idx  (rd_idx),
        .rd_data (rd_data),
        .byte0   (byte0),
        .count   (rx_count),
        .full    (rx_full)
    );

    gfr_frame_seq #(
        .RX_DEPTH (RX_DEPTH)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (in_take && func == FN_STOP),
        .addr_byte (addr_byte),
        .rx_count  (rx_count),
        .byte0     (byte0),
        .rd_data   (rd_data),
        .res_take  (seq_take),
        .rd_idx    (rd_idx),
        .stat      (seq_stat)
    );

    // register writes
    always_comb begin
        own_address_next = own_address_reg;
        stale_limit_next = stale_limit_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_OWN_ADDRESS: own_address_next = cfg_data[6:0];
                CFG_STALE_LIMIT: stale_limit_next = cfg_data;
                default: ;
            endcase
        end
    end

    // kept values, ages and the result built from their next values
    always_comb begin
        percent_store_next = percent_store_reg;
        percent_valid_next = percent_valid_reg;
        percent_age_next   = percent_age_reg;
        current_store_next = current_store_reg;
        current_valid_next = current_valid_reg;
        current_age_next   = current_age_reg;
        accepted = 1'b0;
        kind     = KIND_NONE;
        load     = 1'b0;

        if (seq_take) begin
            // stop finished: commit an accepted frame
            load = 1'b1;
            kind = seq_stat.kind;
            case (seq_stat.kind)
                KIND_PERCENT: begin
                    percent_store_next = seq_stat.value;
                    percent_age_next   = '0;
                    percent_valid_next = 1'b1;
                end
                KIND_CURRENT: begin
                    current_store_next = seq_stat.counts;
                    current_age_next   = '0;
                    current_valid_next = 1'b1;
                end
                default: ;
            endcase
        end else if (in_take) begin
            case (func)
                FN_START: load = 1'b1;
                FN_DATA: begin
                    load     = 1'b1;
                    accepted = !rx_full;
                end
                FN_TICK: begin
                    load = 1'b1;
                    // ages saturate at all ones
                    if (percent_age_reg != '1) begin
                        percent_age_next = percent_age_reg + 32'd1;
                    end
                    if (current_age_reg != '1) begin
                        current_age_next = current_age_reg + 32'd1;
                    end
                end
                default: ;  // stop result comes from the sequencer
            endcase
        end

        out_data_next.pad             = '0;
        out_data_next.byte_accepted   = accepted;
        out_data_next.frame_kind      = kind;
        out_data_next.percent_value   = percent_valid_next ? percent_store_next : 8'hFF;
        out_data_next.percent_present = percent_valid_next;
        out_data_next.percent_fresh   = percent_valid_next &&
                                        (percent_age_next <= {16'd0, stale_limit_reg});
        out_data_next.percent_age_ms  = percent_valid_next ? percent_age_next : '1;
        out_data_next.current_raw     = current_store_next;
        out_data_next.current_present = current_valid_next;
        out_data_next.current_age_ms  = current_age_next;

        if (load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_address_reg   <= OWN_ADDR_RESET;
            stale_limit_reg   <= STALE_RESET;
            percent_store_reg <= '0;
            percent_valid_reg <= 1'b0;
            percent_age_reg   <= '0;
            current_store_reg <= '0;
            current_valid_reg <= 1'b0;
            current_age_reg   <= '0;
            out_valid_reg     <= 1'b0;
        end else begin
            own_address_reg   <= own_address_next;
            stale_limit_reg   <= stale_limit_next;
            percent_store_reg <= percent_store_next;
            percent_valid_reg <= percent_valid_next;
            percent_age_reg   <= percent_age_next;
            current_store_reg <= current_store_next;
            current_valid_reg <= current_valid_next;
            current_age_reg   <= current_age_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (load) begin
            out_data_reg <= out_data_next;
        end
    end

    // a stop request hands control to the sequencer
    a_stop_starts_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_take && func == FN_STOP) |=> !seq_stat.idle)
        else $error("stop request did not start the frame sequencer");

    // seen flags never drop once set
    a_seen_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (percent_valid_reg || current_valid_reg) |=>
        ($past(percent_valid_reg) ? percent_valid_reg : 1'b1) &&
        ($past(current_valid_reg) ? current_valid_reg : 1'b1))
        else $error("seen flag cleared without reset");

    // a percent result always reports a fresh, zero-age value
    a_percent_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_data_reg.frame_kind == KIND_PERCENT) |->
        (out_data_reg.percent_present && out_data_reg.percent_age_ms == '0))
        else $error("percent result without a committed value");

    // fill count stays within the buffer
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rx_count <= CNT_W'(RX_DEPTH))
        else $error("receive count beyond buffer depth");

endmodule
